// ----- src/ism_pkg.sv -----
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types, codes and the microcode store of the integer stack machine.
// ----------------------------------------------------------------------------
`default_nettype none

package ism_pkg;

	// Instruction codes carried by the op field.
	localparam logic [3:0] OP_CONST = 4'd0;
	localparam logic [3:0] OP_ADD   = 4'd1;
	localparam logic [3:0] OP_SUB   = 4'd2;
	localparam logic [3:0] OP_MUL   = 4'd3;
	localparam logic [3:0] OP_DIV   = 4'd4;
	localparam logic [3:0] OP_MAX   = 4'd5;
	localparam logic [3:0] OP_MIN   = 4'd6;
	localparam logic [3:0] OP_NEG   = 4'd7;
	localparam logic [3:0] OP_DUP   = 4'd8;
	localparam logic [3:0] OP_SWAP  = 4'd9;

	// Status codes reported with each result.
	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_UNDER = 2'd1;
	localparam status_t ST_OVER  = 2'd2;
	localparam status_t ST_DIVZ  = 2'd3;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned DIV_BITS = 32;

	// Microcode addresses.
	typedef logic [3:0] uaddr_t;
	localparam uaddr_t U_IDLE  = 4'd0;
	localparam uaddr_t U_DONE  = 4'd1;
	localparam uaddr_t U_CONST = 4'd2;
	localparam uaddr_t U_DUP   = 4'd3;
	localparam uaddr_t U_NEG   = 4'd4;
	localparam uaddr_t U_SWAP  = 4'd5;
	localparam uaddr_t U_SWAP2 = 4'd6;
	localparam uaddr_t U_BIN   = 4'd7;
	localparam uaddr_t U_BIN2  = 4'd8;
	localparam uaddr_t U_DIV   = 4'd9;
	localparam uaddr_t U_DIV2  = 4'd10;
	localparam uaddr_t U_DIV3  = 4'd11;
	localparam uaddr_t U_DIV4  = 4'd12;

	// Precondition tested by a step; a failing test aborts to the publish step.
	typedef enum logic [2:0] {
		CHK_NONE,
		CHK_NEED1,
		CHK_NEED2,
		CHK_ROOM,
		CHK_DUP,
		CHK_DIVZ
	} chk_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_PUSH,
		WR_SWAP
	} wr_t;

	typedef enum logic [2:0] {
		T_HOLD,
		T_VAL,
		T_NEG,
		T_ALU,
		T_RDB,
		T_QUO
	} tsel_t;

	typedef enum logic [1:0] {
		SP_HOLD,
		SP_INC,
		SP_DEC
	} spact_t;

	typedef enum logic [1:0] {
		DV_NONE,
		DV_INIT,
		DV_STEP
	} div_op_t;

	typedef enum logic [2:0] {
		NX_FETCH,
		NX_PUB,
		NX_SEQ,
		NX_DONE,
		NX_LOOP
	} nxt_t;

	typedef struct packed {
		chk_t    chk;
		wr_t     wr;
		tsel_t   tsel;
		spact_t  spact;
		div_op_t div;
		nxt_t    nxt;
	} ucode_t;

	// Conditions fed back from the datapath to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic chk_ok;
		logic div_last;
	} seq_cond_t;

	typedef struct packed {
		logic init;
		logic step;
	} div_ctrl_t;

	function automatic ucode_t uw(input chk_t c, input wr_t w, input tsel_t t,
		input spact_t s, input div_op_t d, input nxt_t n);
		ucode_t r;
		r = '{chk: c, wr: w, tsel: t, spact: s, div: d, nxt: n};
		return r;
	endfunction

	// The control program. Binary operations and SWAP read the second entry
	// in their first step and use the registered read data in the second.
	function automatic ucode_t ucode_rom(input uaddr_t a);
		ucode_t r;
		case (a)
			U_IDLE:  r = uw(CHK_NONE,  WR_NONE, T_HOLD, SP_HOLD, DV_NONE, NX_FETCH);
			U_DONE:  r = uw(CHK_NONE,  WR_NONE, T_HOLD, SP_HOLD, DV_NONE, NX_PUB);
			U_CONST: r = uw(CHK_ROOM,  WR_PUSH, T_VAL,  SP_INC,  DV_NONE, NX_DONE);
			U_DUP:   r = uw(CHK_DUP,   WR_PUSH, T_HOLD, SP_INC,  DV_NONE, NX_DONE);
			U_NEG:   r = uw(CHK_NEED1, WR_NONE, T_NEG,  SP_HOLD, DV_NONE, NX_DONE);
			U_SWAP:  r = uw(CHK_NEED2, WR_NONE, T_HOLD, SP_HOLD, DV_NONE, NX_SEQ);
			U_SWAP2: r = uw(CHK_NONE,  WR_SWAP, T_RDB,  SP_HOLD, DV_NONE, NX_DONE);
			U_BIN:   r = uw(CHK_NEED2, WR_NONE, T_HOLD, SP_HOLD, DV_NONE, NX_SEQ);
			U_BIN2:  r = uw(CHK_NONE,  WR_NONE, T_ALU,  SP_DEC,  DV_NONE, NX_DONE);
			U_DIV:   r = uw(CHK_NEED2, WR_NONE, T_HOLD, SP_HOLD, DV_NONE, NX_SEQ);
			U_DIV2:  r = uw(CHK_DIVZ,  WR_NONE, T_HOLD, SP_HOLD, DV_INIT, NX_SEQ);
			U_DIV3:  r = uw(CHK_NONE,  WR_NONE, T_HOLD, SP_HOLD, DV_STEP, NX_LOOP);
			U_DIV4:  r = uw(CHK_NONE,  WR_NONE, T_QUO,  SP_DEC,  DV_NONE, NX_DONE);
			default: r = uw(CHK_NONE,  WR_NONE, T_HOLD, SP_HOLD, DV_NONE, NX_DONE);
		endcase
		return r;
	endfunction

	// Entry point of each instruction; unused codes go straight to publish.
	function automatic uaddr_t op_entry(input logic [3:0] op);
		uaddr_t r;
		case (op)
			OP_CONST: r = U_CONST;
			OP_ADD:   r = U_BIN;
			OP_SUB:   r = U_BIN;
			OP_MUL:   r = U_BIN;
			OP_DIV:   r = U_DIV;
			OP_MAX:   r = U_BIN;
			OP_MIN:   r = U_BIN;
			OP_NEG:   r = U_NEG;
			OP_DUP:   r = U_DUP;
			OP_SWAP:  r = U_SWAP;
			default:  r = U_DONE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/ism_ram.sv -----
// ----------------------------------------------------------------------------
// ism_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/ism_div.sv -----
// ----------------------------------------------------------------------------
// ism_div
// Restoring signed divider, one quotient bit per step, truncating to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ism_pkg::div_ctrl_t          ctrl,
	input  wire logic signed [ism_pkg::DATA_W-1:0] dividend,
	input  wire logic signed [ism_pkg::DATA_W-1:0] divisor,
	output logic signed [ism_pkg::DATA_W-1:0]      quotient,
	output logic                             last
);

	localparam int unsigned W  = ism_pkg::DATA_W;
	localparam int unsigned CW = $clog2(ism_pkg::DIV_BITS + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;

	logic [W:0]    shifted;
	logic [W:0]    diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.init) begin
			cnt_q <= CW'(ism_pkg::DIV_BITS);
		end else if (ctrl.step) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Magnitudes are taken as unsigned, so the most negative value works.
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
			dvs_q <= divisor[W-1] ? W'(-divisor) : W'(divisor);
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (ctrl.step) begin
			rem_q <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign quotient = neg_q ? $signed(W'(-quo_q)) : $signed(quo_q);
	assign last     = (cnt_q == CW'(1));

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step |-> cnt_q != '0)
		else $error("divider stepped past its last bit");

endmodule

`default_nettype wire

// ----- src/ism_seq.sv -----
// ----------------------------------------------------------------------------
// ism_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [3:0]          op,
	input  wire ism_pkg::seq_cond_t  cond,
	output ism_pkg::ucode_t          ctrl
);

	ism_pkg::uaddr_t upc_q;
	ism_pkg::uaddr_t upc_next;
	ism_pkg::uaddr_t upc_inc;

	assign ctrl    = ism_pkg::ucode_rom(upc_q);
	assign upc_inc = ism_pkg::uaddr_t'(upc_q + 1'b1);

	always_comb begin
		upc_next = upc_q;
		if (!cond.chk_ok) begin
			upc_next = ism_pkg::U_DONE;
		end else begin
			case (ctrl.nxt)
				ism_pkg::NX_FETCH: begin
					if (cond.in_valid) upc_next = ism_pkg::op_entry(op);
				end
				ism_pkg::NX_PUB: begin
					if (cond.out_free) upc_next = ism_pkg::U_IDLE;
				end
				ism_pkg::NX_SEQ:  upc_next = upc_inc;
				ism_pkg::NX_DONE: upc_next = ism_pkg::U_DONE;
				ism_pkg::NX_LOOP: begin
					if (cond.div_last) upc_next = upc_inc;
				end
				default: upc_next = ism_pkg::U_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ism_pkg::U_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

`default_nettype wire

// ----- src/integer_stack_machine.sv -----
// ----------------------------------------------------------------------------
// integer_stack_machine
// Stack-machine interpreter over a stack of 32-bit signed operands.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------
//   in       | request   | in_valid / in_ready    | op, push_value
//   out      | result    | out_valid / out_ready  | top_value, stack_count, status
//
// Unused codes go straight to the publish step; SWAP, ADD, SUB, MUL, MAX and
// MIN read the second entry before writing, and DIV is set by the 32 steps
// of the restoring divider. Failed checks publish early.
// Reset clears the stack pointer and the sequencer; the operand store is not
// cleared, as only entries that have been written are ever read.
// A stalled output holds the sequencer in its publish step; a new request is
// taken as soon as the result has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_stack_machine #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [3:0]         op,
	input  wire logic signed [31:0] push_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      top_value,
	output logic [6:0]              stack_count,
	output logic [1:0]              status
);

	localparam int unsigned AW  = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam logic [SPW-1:0] FULL = SPW'(STACK_DEPTH);

	// The top of the stack lives in t_q; the store holds the entries below it.
	logic [SPW-1:0]         sp_q;
	logic signed [31:0]     t_q;
	logic [3:0]             op_q;
	logic signed [31:0]     val_q;
	ism_pkg::status_t       status_q;
	logic                   out_valid_q;

	ism_pkg::ucode_t        ctrl;
	ism_pkg::seq_cond_t     cond;
	ism_pkg::div_ctrl_t     div_ctrl;

	logic [SPW-1:0]         sp_m1;
	logic [SPW-1:0]         sp_m2;
	logic                   chk_ok;
	ism_pkg::status_t       fail_status;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [31:0]            ram_rdata;
	logic signed [31:0]     b_val;
	logic signed [31:0]     alu_res;
	logic signed [31:0]     quotient;
	logic                   div_last;
	logic                   out_free;
	logic                   pub;
	logic                   accept;

	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);
	assign b_val = $signed(ram_rdata);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (ctrl.nxt == ism_pkg::NX_FETCH);
	assign accept   = in_valid && in_ready;
	assign pub      = (ctrl.nxt == ism_pkg::NX_PUB) && out_free;

	// Precondition of the current step and the status it reports on failure.
	always_comb begin
		chk_ok      = 1'b1;
		fail_status = ism_pkg::ST_OK;
		case (ctrl.chk)
			ism_pkg::CHK_NONE: chk_ok = 1'b1;
			ism_pkg::CHK_NEED1: begin
				chk_ok      = (sp_q != '0);
				fail_status = ism_pkg::ST_UNDER;
			end
			ism_pkg::CHK_NEED2: begin
				chk_ok      = (sp_q >= SPW'(2));
				fail_status = ism_pkg::ST_UNDER;
			end
			ism_pkg::CHK_ROOM: begin
				chk_ok      = (sp_q != FULL);
				fail_status = ism_pkg::ST_OVER;
			end
			ism_pkg::CHK_DUP: begin
				chk_ok      = (sp_q != '0) && (sp_q != FULL);
				fail_status = (sp_q == '0) ? ism_pkg::ST_UNDER : ism_pkg::ST_OVER;
			end
			ism_pkg::CHK_DIVZ: begin
				chk_ok      = (ram_rdata != '0);
				fail_status = ism_pkg::ST_DIVZ;
			end
			default: chk_ok = 1'b1;
		endcase
	end

	// The top is operand a and the read entry is operand b.
	always_comb begin
		case (op_q)
			ism_pkg::OP_ADD: alu_res = t_q + b_val;
			ism_pkg::OP_SUB: alu_res = t_q - b_val;
			ism_pkg::OP_MUL: alu_res = t_q * b_val;
			ism_pkg::OP_MAX: alu_res = (t_q < b_val) ? b_val : t_q;
			ism_pkg::OP_MIN: alu_res = (t_q < b_val) ? t_q : b_val;
			default:         alu_res = t_q;
		endcase
	end

	// A push spills the old top below the new one; a swap writes the old top
	// into the second place while the second entry moves up into t_q.
	assign ram_we = chk_ok && (((ctrl.wr == ism_pkg::WR_PUSH) && (sp_q != '0)) ||
		(ctrl.wr == ism_pkg::WR_SWAP));
	assign ram_waddr = (ctrl.wr == ism_pkg::WR_PUSH) ? sp_m1[AW-1:0] : sp_m2[AW-1:0];

	assign div_ctrl.init = chk_ok && (ctrl.div == ism_pkg::DV_INIT);
	assign div_ctrl.step = (ctrl.div == ism_pkg::DV_STEP);

	assign cond.in_valid = in_valid;
	assign cond.out_free = out_free;
	assign cond.chk_ok   = chk_ok;
	assign cond.div_last = div_last;

	ism_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	ism_ram #(
		.WIDTH (32),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (t_q),
		.raddr (sp_m2[AW-1:0]),
		.rdata (ram_rdata)
	);

	ism_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (t_q),
		.divisor  (b_val),
		.quotient (quotient),
		.last     (div_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			status_q    <= ism_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				status_q <= ism_pkg::ST_OK;
			end else if (!chk_ok) begin
				status_q <= fail_status;
			end
			if (chk_ok) begin
				case (ctrl.spact)
					ism_pkg::SP_INC: sp_q <= sp_q + SPW'(1);
					ism_pkg::SP_DEC: sp_q <= sp_m1;
					default:         sp_q <= sp_q;
				endcase
			end
			if (pub) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			val_q <= push_value;
		end
		if (chk_ok) begin
			case (ctrl.tsel)
				ism_pkg::T_VAL: t_q <= val_q;
				ism_pkg::T_NEG: t_q <= -t_q;
				ism_pkg::T_ALU: t_q <= alu_res;
				ism_pkg::T_RDB: t_q <= b_val;
				ism_pkg::T_QUO: t_q <= quotient;
				default:        t_q <= t_q;
			endcase
		end
		if (pub) begin
			top_value   <= (sp_q != '0) ? t_q : 32'sd0;
			stack_count <= 7'(sp_q);
			status      <= status_q;
		end
	end

	assign out_valid = out_valid_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= FULL)
		else $error("stack pointer beyond the stack depth");

	a_idle_holds_sp: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |=> sp_q == $past(sp_q))
		else $error("stack pointer moved while waiting for a request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(pub && out_valid_q && !out_ready))
		else $error("result published over one not yet taken");

	a_divz_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == ism_pkg::ST_DIVZ) |-> (op_q == ism_pkg::OP_DIV))
		else $error("divide-by-zero status on an instruction other than DIV");

endmodule

`default_nettype wire
